/* design/tscf_pkg.sv */
// Shared constants, character codes and types for the text stream cat filter.
package tscf_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 1;
    localparam int BCD_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_NONBLANK  = 3'd0,
        REG_NUMBER_ALL       = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } t_reg_idx;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CTRL_MAX     = 8'h1F;
    localparam logic [7:0] HIGH_MIN     = 8'h80;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    localparam logic [BCD_W-1:0] BCD_NINE = 4'd9;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // Work description handed from the front to the back for one input word.
    typedef struct packed {
        logic       has_prefix;
        logic       is_number;
        logic       has_pre;
        logic [7:0] pre_byte;
        logic [7:0] main_byte;
    } t_job_ctl;

    localparam int JOB_CTL_W = $bits(t_job_ctl);

endpackage

/* design/tscf_front.sv */
// Front end: accepts input words, tracks line state and the BCD line counter, builds jobs.
module tscf_front #(
    parameter int NUMBER_DIGITS = tscf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tscf_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_byte,
    input  logic                       i_q_full,
    output logic                       o_push,
    output tscf_pkg::t_job_ctl         o_ctl,
    output logic [4*NUMBER_DIGITS-1:0] o_digits
);
    import tscf_pkg::*;

    localparam int DIG_W = BCD_W * NUMBER_DIGITS;
    localparam logic [DIG_W-1:0] BCD_ONE = DIG_W'(1);

    logic             r_at_line_start;
    logic [1:0]       r_blank_run;
    logic [DIG_W-1:0] r_line_bcd;

    logic             is_nl;
    logic             is_tab;
    logic             drop;
    logic             do_number;
    logic             do_spaces;
    logic             accept;
    logic [1:0]       n_blank_run;
    logic [DIG_W-1:0] n_line_bcd;
    t_job_ctl         ctl;

    // Saturating BCD increment: ripple through the digits, hold at all nines.
    always_comb begin
        logic carry;
        logic all_nines;
        carry      = 1'b1;
        all_nines  = 1'b1;
        n_line_bcd = r_line_bcd;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (r_line_bcd[BCD_W*i +: BCD_W] != BCD_NINE) begin
                all_nines = 1'b0;
            end
            if (carry) begin
                if (r_line_bcd[BCD_W*i +: BCD_W] >= BCD_NINE) begin
                    n_line_bcd[BCD_W*i +: BCD_W] = '0;
                end else begin
                    n_line_bcd[BCD_W*i +: BCD_W] = r_line_bcd[BCD_W*i +: BCD_W] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines) begin
            n_line_bcd = r_line_bcd;
        end
    end

    always_comb begin
        is_nl       = (i_byte == CH_NL);
        is_tab      = (i_byte == CH_TAB);
        n_blank_run = r_blank_run;
        drop        = 1'b0;
        do_number   = 1'b0;
        do_spaces   = 1'b0;

        if (r_at_line_start) begin
            if (is_nl) begin
                n_blank_run = (r_blank_run == 2'd3) ? 2'd3 : r_blank_run + 2'd1;
            end else begin
                n_blank_run = 2'd0;
            end
            drop = i_cfg.squeeze_blank && (n_blank_run > 2'd1);
            if (!drop) begin
                if (i_cfg.number_nonblank) begin
                    do_number = !is_nl;
                    do_spaces = is_nl && i_cfg.show_ends;
                end else begin
                    do_number = i_cfg.number_all;
                end
            end
        end

        ctl.has_prefix = do_number || do_spaces;
        ctl.is_number  = do_number;
        ctl.has_pre    = 1'b0;
        ctl.pre_byte   = CH_CARET;
        ctl.main_byte  = i_byte;

        if (i_cfg.show_tabs && is_tab) begin
            ctl.has_pre   = 1'b1;
            ctl.main_byte = CH_I;
        end else if (i_cfg.show_ends && is_nl) begin
            ctl.has_pre  = 1'b1;
            ctl.pre_byte = CH_DOLLAR;
        end else if (i_cfg.show_nonprinting && !is_nl && !is_tab) begin
            if (i_byte <= CTRL_MAX || i_byte >= HIGH_MIN) begin
                ctl.has_pre   = 1'b1;
                ctl.main_byte = i_byte + CARET_OFFSET;
            end else if (i_byte == CH_DEL) begin
                ctl.has_pre   = 1'b1;
                ctl.main_byte = CH_QMARK;
            end
        end
    end

    assign accept   = i_valid && !i_q_full;
    assign o_ready  = !i_q_full;
    assign o_push   = accept && !drop;
    assign o_ctl    = ctl;
    assign o_digits = r_line_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_blank_run     <= 2'd0;
            r_line_bcd      <= BCD_ONE;
        end else if (accept) begin
            r_at_line_start <= is_nl;
            r_blank_run     <= n_blank_run;
            if (do_number) begin
                r_line_bcd <= n_line_bcd;
            end
        end
    end

endmodule

/* design/tscf_queue.sv */
// Small synchronous FIFO that decouples the front end from the back end.
module tscf_queue #(
    parameter int WIDTH = tscf_pkg::JOB_CTL_W,
    parameter int DEPTH = tscf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    import tscf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/tscf_back.sv */
// Back end: walks one job at a time and emits its bytes through an output register.
module tscf_back #(
    parameter int NUMBER_DIGITS = tscf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  tscf_pkg::t_job_ctl         i_ctl,
    input  logic [4*NUMBER_DIGITS-1:0] i_digits,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_byte,
    output logic                       o_last
);
    import tscf_pkg::*;

    localparam int DIG_W = BCD_W * NUMBER_DIGITS;
    localparam int IW    = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUMBER_DIGITS - 1);

    typedef enum logic [1:0] {
        PH_DIGIT,
        PH_TAB,
        PH_PRE,
        PH_MAIN
    } t_phase;

    logic             r_busy;
    t_phase           r_phase;
    logic [IW-1:0]    r_idx;
    logic             r_seen;
    t_job_ctl         r_ctl;
    logic [DIG_W-1:0] r_digits;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             out_free;
    logic             emit;
    logic             done;
    logic             pop;
    logic             show;
    logic [3:0]       cur_digit;
    logic [3:0]       clamp_digit;
    logic [7:0]       cur_byte;
    logic             cur_last;
    t_phase           load_phase;

    always_comb begin
        cur_digit   = r_digits[BCD_W*r_idx +: BCD_W];
        clamp_digit = (cur_digit > BCD_NINE) ? BCD_NINE : cur_digit;
        // Leading zeros print as spaces; in a numbered job the units digit always prints.
        show = r_ctl.is_number && (r_seen || (cur_digit != 4'd0) || (r_idx == '0));
        cur_last = 1'b0;
        unique case (r_phase)
            PH_DIGIT: cur_byte = show ? (CH_ZERO + {4'd0, clamp_digit}) : CH_SPACE;
            PH_TAB:   cur_byte = CH_TAB;
            PH_PRE:   cur_byte = r_ctl.pre_byte;
            PH_MAIN: begin
                cur_byte = r_ctl.main_byte;
                cur_last = 1'b1;
            end
            default:  cur_byte = r_ctl.main_byte;
        endcase

        out_free = !r_out_valid || i_ready;
        emit     = r_busy && out_free;
        done     = emit && (r_phase == PH_MAIN);
        pop      = !i_q_empty && (!r_busy || done);

        if (i_ctl.has_prefix) begin
            load_phase = PH_DIGIT;
        end else if (i_ctl.has_pre) begin
            load_phase = PH_PRE;
        end else begin
            load_phase = PH_MAIN;
        end
    end

    assign o_pop   = pop;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_MAIN;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                r_out_byte <= cur_byte;
                r_out_last <= cur_last;
            end

            if (pop) begin
                r_busy   <= 1'b1;
                r_ctl    <= i_ctl;
                r_digits <= i_digits;
                r_phase  <= load_phase;
                r_idx    <= LAST_IDX;
                r_seen   <= 1'b0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                unique case (r_phase)
                    PH_DIGIT: begin
                        r_seen <= r_seen || show;
                        if (r_idx == '0) begin
                            r_phase <= PH_TAB;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                    PH_TAB:  r_phase <= r_ctl.has_pre ? PH_PRE : PH_MAIN;
                    PH_PRE:  r_phase <= PH_MAIN;
                    default: r_phase <= PH_MAIN;
                endcase
            end
        end
    end

endmodule

/* design/text_stream_cat_filter_top.sv */
// Top level of the text stream cat filter: configuration registers, front end, queue, back end.
// A word accepted into an idle block goes through the job queue, the back end's job registers
// and the output register. Throughput: one input word per cycle while each word yields one byte
// and no stall; a longer job holds the back end, and the four-entry job queue lets input run ahead.
// Reset is synchronous and active low: it empties the queue and output register, clears all
// options, returns to line start with no blank run, and sets the line counter to one.
module text_stream_cat_filter_top #(
    parameter int NUMBER_DIGITS = tscf_pkg::NUMBER_DIGITS_DEF,
    parameter int QUEUE_DEPTH   = tscf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tscf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tscf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_run
);
    import tscf_pkg::*;

    localparam int DIG_W = BCD_W * NUMBER_DIGITS;
    localparam int JOB_W = JOB_CTL_W + DIG_W;

    // Option bits. The host must write them only while the block is drained; the block does not enforce it.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data[0];
                REG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data[0];
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front end classifies each word as it is accepted. Line state and the counter
    // advance right away, so the job carries a snapshot of the number to print.
    logic             f_push;
    t_job_ctl         f_ctl;
    logic [DIG_W-1:0] f_digits;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [JOB_W-1:0] q_rdata;
    t_job_ctl         b_ctl;
    logic [DIG_W-1:0] b_digits;

    tscf_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_byte   (i_in_byte),
        .i_q_full (q_full),
        .o_push   (f_push),
        .o_ctl    (f_ctl),
        .o_digits (f_digits)
    );

    // Dropped words (squeezed blank lines) never enter the queue.
    tscf_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_ctl, f_digits}),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_ctl    = t_job_ctl'(q_rdata[JOB_W-1 -: JOB_CTL_W]);
    assign b_digits = q_rdata[DIG_W-1:0];

    // The back end emits one byte per cycle unless the output stalls: digits and tab if the job
    // has a prefix, optional lead byte, then the main byte, which carries the last-of-run flag.
    tscf_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_ctl     (b_ctl),
        .i_digits  (b_digits),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_byte    (o_out_byte),
        .o_last    (o_last_of_run)
    );

endmodule

/* design/tscf_checker.sv */
// Port-level assertions for the text stream cat filter, bound to the top level.
module tscf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    // Coming out of reset the block is empty and ready for input.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not empty after reset");

    // A stalled output word holds its byte and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("stalled output word changed");

    // A run is never cut short: the output goes idle only after a last byte is taken.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_out_valid) && $past(i_rst_n)) |-> $past(o_last_of_run && i_out_ready))
        else $error("output went idle in the middle of a run");

endmodule

bind text_stream_cat_filter_top tscf_checker u_tscf_checker (.*);

/* tb/tb_text_stream_cat_filter_top.sv */
// Self-checking testbench for the text stream cat filter: directed table, random text, checker.
`timescale 1ns / 1ps

module tb_text_stream_cat_filter_top;
    import tscf_pkg::*;

    // Number of BCD digits in the line counter, matching the default build of the block.
    localparam int DIGITS = NUMBER_DIGITS_DEF;

    // Cycles allowed after the last expected word before options change, so that the
    // block has settled back to idle.
    localparam int CFG_SETTLE = 12;
    // Cycles watched for stray words once the stimulus is done.
    localparam int END_DRAIN = 20;
    // The watchdog fires after this many cycles in which no word moves on either side.
    localparam int WATCHDOG_LIMIT = 2000;
    // The receiver holds off once, for HOLD_CYCLES, after this many output words, starting
    // at a cycle in which the sender is offering a word.
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 60;
    // Least number of input words in each random phase.
    localparam int PHASE_WORDS = 26;

    // Option settings used by the directed table. The bit order follows t_cfg:
    // nonblank, all, squeeze, ends, tabs, nonprinting.
    localparam t_cfg OPTS_NONE      = 6'b000000;
    localparam t_cfg OPTS_SHOW      = 6'b000111;
    localparam t_cfg OPTS_ALL_SQZ   = 6'b011000;
    localparam t_cfg OPTS_NB_ENDS   = 6'b110100;
    localparam t_cfg OPTS_NONBLANK  = 6'b100000;

    // One expected output word.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    // One row of the directed table. A negative n_typed means the expected words come
    // from the formatter model; otherwise the first n_typed bytes of typed_bytes,
    // most significant byte first, are the expected words.
    typedef struct packed {
        t_cfg              opts;
        logic [7:0]        in_byte;
        logic signed [3:0] n_typed;
        logic [23:0]       typed_bytes;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [7:0]            i_in_byte   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [7:0]            o_out_byte;
    logic                  o_last_of_run;

    text_stream_cat_filter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Formatter model state: the options as written, the line start flag, the count of
    // consecutive blank lines and the BCD line number.
    t_cfg                fmt_opts    = '0;
    logic                at_start    = 1'b1;
    logic [1:0]          blank_lines = 2'd0;
    logic [4*DIGITS-1:0] line_bcd    = (4*DIGITS)'(1);

    // Bytes produced by the model for the current input word.
    logic [7:0] fmt_buf [0:15];
    int         fmt_len;

    // Words still owed by the block, oldest first.
    t_out_word  formatted_q [$];
    t_row       rows [$];

    int         failures    = 0;
    int         words_seen  = 0;
    int         idle_cycles = 0;
    logic [15:0] cyc        = '0;
    t_out_word  want_word;

    // Both sides run without any idling while bit 7 of the cycle count is high, except during
    // the long hold-off, so that stretches at full rate alternate with stretches full of gaps.
    wire calm = cyc[7];

    always @(posedge i_clk) begin
        cyc <= cyc + 16'd1;
    end

    function automatic void add_char(input logic [7:0] c);
        fmt_buf[fmt_len] = c;
        fmt_len++;
    endfunction

    // Appends the right-aligned line number and a tab, then steps the counter unless every
    // digit is already nine.
    function automatic void add_line_number();
        logic       seen;
        logic       all_nines;
        logic       carry;
        logic [3:0] d;
        seen      = 1'b0;
        all_nines = 1'b1;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            d = line_bcd[4*i +: 4];
            if (d != 4'd0 || i == 0)
                seen = 1'b1;
            if (d > BCD_NINE)
                d = BCD_NINE;
            add_char(seen ? CH_ZERO + {4'h0, d} : CH_SPACE);
            if (line_bcd[4*i +: 4] != BCD_NINE)
                all_nines = 1'b0;
        end
        add_char(CH_TAB);
        carry = !all_nines;
        for (int i = 0; i < DIGITS; i++) begin
            if (carry) begin
                if (line_bcd[4*i +: 4] >= BCD_NINE) begin
                    line_bcd[4*i +: 4] = 4'd0;
                end else begin
                    line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    endfunction

    // Formats one input byte into fmt_buf and returns the number of output words.
    function automatic int format_byte(input logic [7:0] b);
        logic       blank;
        logic [7:0] c;
        fmt_len = 0;
        if (at_start) begin
            blank = (b == CH_NL);
            if (!blank)
                blank_lines = 2'd0;
            else if (blank_lines < 2'd3)
                blank_lines = blank_lines + 2'd1;
            // A squeezed blank line vanishes and the next byte still starts a line.
            if (fmt_opts.squeeze_blank && blank_lines > 2'd1)
                return 0;
            if (fmt_opts.number_nonblank) begin
                if (!blank) begin
                    add_line_number();
                end else if (fmt_opts.show_ends) begin
                    repeat (DIGITS) add_char(CH_SPACE);
                    add_char(CH_TAB);
                end
            end else if (fmt_opts.number_all) begin
                add_line_number();
            end
        end
        if (fmt_opts.show_tabs && b == CH_TAB) begin
            add_char(CH_CARET);
            add_char(CH_I);
        end else begin
            c = b;
            if (fmt_opts.show_ends && b == CH_NL)
                add_char(CH_DOLLAR);
            if (fmt_opts.show_nonprinting && b != CH_NL && b != CH_TAB) begin
                if (b <= CTRL_MAX || b >= HIGH_MIN) begin
                    add_char(CH_CARET);
                    c = b + CARET_OFFSET;
                end else if (b == CH_DEL) begin
                    add_char(CH_CARET);
                    c = CH_QMARK;
                end
            end
            add_char(c);
        end
        at_start = (b == CH_NL);
        return fmt_len;
    endfunction

    // Gap length: mostly none, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // A byte that may appear inside a line of text: mostly printable, with tabs, control
    // bytes, high bytes and DEL mixed in. Newlines are left to the line generator.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 55)
            c = 8'($urandom_range(32, 126));
        else if (r < 67)
            c = CH_TAB;
        else if (r < 82)
            c = 8'($urandom_range(0, 31));
        else if (r < 94)
            c = 8'($urandom_range(128, 255));
        else
            c = CH_DEL;
        if (c == CH_NL)
            c = CH_SPACE;
        return c;
    endfunction

    task automatic add_row(input t_cfg opts, input logic [7:0] b,
                           input logic signed [3:0] n, input logic [23:0] typed);
        rows.push_back({opts, b, n, typed});
    endtask

    // Writes one option register and mirrors it into the model.
    task automatic write_reg(input t_reg_idx idx, input logic v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        unique case (idx)
            REG_NUMBER_NONBLANK:  fmt_opts.number_nonblank  = v;
            REG_NUMBER_ALL:       fmt_opts.number_all       = v;
            REG_SQUEEZE_BLANK:    fmt_opts.squeeze_blank    = v;
            REG_SHOW_ENDS:        fmt_opts.show_ends        = v;
            REG_SHOW_TABS:        fmt_opts.show_tabs        = v;
            REG_SHOW_NONPRINTING: fmt_opts.show_nonprinting = v;
            default: ;
        endcase
    endtask

    // Options only change while the block is idle: every owed word has arrived and the
    // block has had a few cycles to settle.
    task automatic apply_cfg(input t_cfg want);
        i_in_valid <= 1'b0;
        while (formatted_q.size() != 0)
            @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        write_reg(REG_NUMBER_NONBLANK,  want.number_nonblank);
        write_reg(REG_NUMBER_ALL,       want.number_all);
        write_reg(REG_SQUEEZE_BLANK,    want.squeeze_blank);
        write_reg(REG_SHOW_ENDS,        want.show_ends);
        write_reg(REG_SHOW_TABS,        want.show_tabs);
        write_reg(REG_SHOW_NONPRINTING, want.show_nonprinting);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one input word, waits for the handshake and records the words it should cause.
    // Valid stays high from one word to the next when there is no gap between them.
    task automatic put_byte(input logic [7:0] b, input logic signed [3:0] n_typed,
                            input logic [23:0] typed);
        int gap;
        int n;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        // The model always runs so that its state follows the block; a typed row then
        // replaces the words it produced.
        n = format_byte(b);
        if (n_typed >= 0) begin
            n = n_typed;
            for (int k = 0; k < n; k++)
                fmt_buf[k] = typed[23-8*k -: 8];
        end
        for (int k = 0; k < n; k++)
            formatted_q.push_back({fmt_buf[k], k == n - 1});
    endtask

    // Output side: checks each accepted word against the oldest expectation and drives
    // ready with random stalls, one long hold-off, and calm stretches at full rate.
    int stall_left = 0;
    int hold_left  = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            if (formatted_q.size() == 0) begin
                failures++;
                $display("%0t: output word %02h (last %0b) arrived with none expected",
                         $time, o_out_byte, o_last_of_run);
            end else begin
                want_word = formatted_q.pop_front();
                if (o_out_byte !== want_word.data) begin
                    failures++;
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want_word.data, o_out_byte);
                end
                if (o_last_of_run !== want_word.last) begin
                    failures++;
                    $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                             $time, want_word.last, o_last_of_run);
                end
            end
        end

        // The long hold-off lets the job queue fill so that the block stalls its input.
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && words_seen >= HOLD_AT && i_in_valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: a run in which no word moves for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles, %0d words still owed",
                     $time, WATCHDOG_LIMIT, formatted_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_cfg opts_next;
        int   sent;
        int   len;

        // Directed table. Plain pass-through right after reset, including both byte extremes.
        add_row(OPTS_NONE, 8'h41, 4'sd1, {8'h41, 16'h0});
        add_row(OPTS_NONE, 8'h00, 4'sd1, {8'h00, 16'h0});
        add_row(OPTS_NONE, 8'hFF, 4'sd1, {8'hFF, 16'h0});
        add_row(OPTS_NONE, CH_NL, 4'sd1, {CH_NL, 16'h0});
        // Caret notation at the edges of the control, DEL and high ranges, the tab as ^I,
        // a space and a tilde passing through, and the dollar before a newline.
        add_row(OPTS_SHOW, 8'h00, 4'sd2, {CH_CARET, 8'h40, 8'h0});
        add_row(OPTS_SHOW, 8'h1F, 4'sd2, {CH_CARET, 8'h5F, 8'h0});
        add_row(OPTS_SHOW, 8'h20, 4'sd1, {8'h20, 16'h0});
        add_row(OPTS_SHOW, CH_DEL, 4'sd2, {CH_CARET, CH_QMARK, 8'h0});
        add_row(OPTS_SHOW, 8'h80, 4'sd2, {CH_CARET, 8'hC0, 8'h0});
        add_row(OPTS_SHOW, 8'hFF, 4'sd2, {CH_CARET, 8'h3F, 8'h0});
        add_row(OPTS_SHOW, CH_TAB, 4'sd2, {CH_CARET, CH_I, 8'h0});
        add_row(OPTS_SHOW, 8'h7E, 4'sd1, {8'h7E, 16'h0});
        add_row(OPTS_SHOW, CH_NL, 4'sd2, {CH_DOLLAR, CH_NL, 8'h0});
        // Number every line with squeezing: a numbered line, one numbered blank line, then
        // two squeezed blank lines (the second with the blank count saturated).
        add_row(OPTS_ALL_SQZ, 8'h78, -4'sd1, 24'h0);
        add_row(OPTS_ALL_SQZ, CH_NL, -4'sd1, 24'h0);
        add_row(OPTS_ALL_SQZ, CH_NL, -4'sd1, 24'h0);
        add_row(OPTS_ALL_SQZ, CH_NL, 4'sd0, 24'h0);
        add_row(OPTS_ALL_SQZ, CH_NL, 4'sd0, 24'h0);
        add_row(OPTS_ALL_SQZ, 8'h79, -4'sd1, 24'h0);
        // Nonblank numbering overriding number-all, with show-ends: a blank line gets six
        // spaces, a tab, the dollar and the newline, the longest run of words.
        add_row(OPTS_NB_ENDS, CH_NL, -4'sd1, 24'h0);
        add_row(OPTS_NB_ENDS, CH_NL, -4'sd1, 24'h0);
        add_row(OPTS_NB_ENDS, 8'h7A, -4'sd1, 24'h0);
        add_row(OPTS_NB_ENDS, CH_TAB, -4'sd1, 24'h0);
        add_row(OPTS_NB_ENDS, CH_NL, -4'sd1, 24'h0);
        // Nonblank numbering without show-ends leaves a blank line unprefixed.
        add_row(OPTS_NONBLANK, CH_NL, 4'sd1, {CH_NL, 16'h0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].opts != fmt_opts)
                apply_cfg(rows[i].opts);
            put_byte(rows[i].in_byte, rows[i].n_typed, rows[i].typed_bytes);
        end

        // Random phases: every option on, every option off, then random settings. Most of
        // the stream is lines of text, some followed by runs of blank lines; the rest is
        // raw noise over the whole byte range.
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0)
                opts_next = '1;
            else if (phase == 1)
                opts_next = '0;
            else
                opts_next = 6'($urandom_range(0, 63));
            apply_cfg(opts_next);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(0, 9) < 7) begin
                    len = $urandom_range(0, 8);
                    repeat (len) put_byte(pick_text_byte(), -4'sd1, 24'h0);
                    put_byte(CH_NL, -4'sd1, 24'h0);
                    sent += len + 1;
                    if ($urandom_range(0, 3) == 0) begin
                        len = $urandom_range(1, 4);
                        repeat (len) put_byte(CH_NL, -4'sd1, 24'h0);
                        sent += len;
                    end
                end else begin
                    len = $urandom_range(1, 5);
                    repeat (len) put_byte(8'($urandom_range(0, 255)), -4'sd1, 24'h0);
                    sent += len;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (formatted_q.size() != 0)
            @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
